FILE: sv/blem_pkg.sv
`default_nettype none

package blem_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int LANES     = 4;
    localparam int ROWS      = MEM_BYTES / LANES;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int LIMIT_W   = $clog2(MEM_BYTES) + 1;
    localparam int CFG_W     = 17;

    localparam logic [7:0] FILL_BYTE = 8'ha5;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef logic [1:0] t_asize;
    localparam t_asize ASZ_BYTE = 2'd0;
    localparam t_asize ASZ_HALF = 2'd1;
    localparam t_asize ASZ_WORD = 2'd2;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic             is_write;
        t_asize           asz;
        logic             sx;
        logic [1:0]       off;
        logic [LANES-1:0] byte_ok;
    } t_s1_ctl;

    function automatic logic [LIMIT_W-1:0] usable_size(input logic [CFG_W-1:0] sz);
        logic [31:0] rnd;
        rnd = (32'(sz) + 32'd15) & 32'hffff_fff0;
        if (rnd > 32'(MEM_BYTES)) begin
            rnd = 32'(MEM_BYTES);
        end
        return rnd[LIMIT_W-1:0];
    endfunction

    localparam logic [LIMIT_W-1:0] RESET_LIMIT = usable_size(17'h10000);

endpackage

`default_nettype wire

FILE: sv/blem_bank.sv
`default_nettype none

module blem_bank (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [blem_pkg::ROW_W-1:0] i_addr,
    input  wire logic [7:0]               i_wdata,
    output logic      [7:0]               o_rdata
);

    logic [7:0] r_mem [blem_pkg::ROWS];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/byte_addressed_little_endian_memory.sv
// A request is registered with its bank reads, then in the output register when that is
// empty or taken. Throughput: one request per cycle unless both stages are full and the
// output stalls; the byte banks are read or written once per request. Reset: synchronous,
// active low; sets the usable size to 65536; a clearing pass fills every byte with 0xa5.
// No request is accepted during the clearing pass; configuration writes are.
`default_nettype none

module byte_addressed_little_endian_memory (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [blem_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    input  wire logic [63:0]                  i_s_tdata,  // address, write_data
    input  wire logic [3:0]                   i_s_tuser,  // cmd, access_size, sign_extend
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    output logic [31:0]                       o_m_tdata,  // read_data
    output logic                              o_m_tuser   // out_of_range
);

    blem_pkg::t_state r_state, n_state;
    logic [blem_pkg::ROW_W-1:0]   r_clr_row, n_clr_row;
    logic [blem_pkg::LIMIT_W-1:0] r_limit;

    logic               r_s1_valid;
    blem_pkg::t_s1_ctl  r_s1, n_s1;
    logic               r_s1_oor, n_s1_oor;

    logic        r_out_valid;
    logic [31:0] r_out_data, n_out_data;
    logic        r_out_oor;

    logic        s_accept, s1_move;
    logic        in_write, in_sx;
    blem_pkg::t_asize in_asz;
    logic [31:0] in_addr, in_wdata;

    logic [31:0] lane_addr [blem_pkg::LANES];
    logic [blem_pkg::LANES-1:0] byte_act, byte_in;

    logic [blem_pkg::LANES-1:0] bank_we, bank_re;
    logic [blem_pkg::ROW_W-1:0] bank_addr  [blem_pkg::LANES];
    logic [7:0]                 bank_wdata [blem_pkg::LANES];
    logic [7:0]                 bank_rdata [blem_pkg::LANES];

    assign in_addr  = i_s_tdata[31:0];
    assign in_wdata = i_s_tdata[63:32];
    assign in_write = i_s_tuser[0];
    assign in_asz   = i_s_tuser[2:1];
    assign in_sx    = i_s_tuser[3];

    assign o_cfg_ready = 1'b1;
    assign s1_move     = r_s1_valid & (~r_out_valid | i_m_tready);
    assign o_s_tready  = (r_state == blem_pkg::ST_RUN) &
                         (~r_s1_valid | ~r_out_valid | i_m_tready);
    assign s_accept    = i_s_tvalid & o_s_tready;

    always_comb begin
        n_state   = r_state;
        n_clr_row = r_clr_row;
        case (r_state)
            blem_pkg::ST_CLEAR: begin
                n_clr_row = r_clr_row + 1'b1;
                if (r_clr_row == blem_pkg::ROW_W'(blem_pkg::ROWS - 1)) begin
                    n_state = blem_pkg::ST_RUN;
                end
            end
            blem_pkg::ST_RUN: begin
                n_state = blem_pkg::ST_RUN;
            end
            default: begin
                n_state = blem_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        byte_act[0] = 1'b1;
        byte_act[1] = (in_asz != blem_pkg::ASZ_BYTE);
        byte_act[2] = (in_asz != blem_pkg::ASZ_BYTE) && (in_asz != blem_pkg::ASZ_HALF);
        byte_act[3] = byte_act[2];
        for (int i = 0; i < blem_pkg::LANES; i++) begin
            lane_addr[i] = in_addr + 32'(i);
            byte_in[i]   = lane_addr[i] < 32'(r_limit);
        end
        n_s1.is_write = (in_write == blem_pkg::CMD_WRITE);
        n_s1.asz      = in_asz;
        n_s1.sx       = in_sx;
        n_s1.off      = in_addr[1:0];
        n_s1.byte_ok  = byte_act & byte_in;
        n_s1_oor      = |(byte_act & ~byte_in);
    end

    // route byte i of the request to bank (address + i) mod 4
    always_comb begin
        logic [1:0] idx;
        logic       en;
        for (int b = 0; b < blem_pkg::LANES; b++) begin
            idx = 2'(b) - in_addr[1:0];
            en  = s_accept & n_s1.byte_ok[idx];
            if (r_state == blem_pkg::ST_CLEAR) begin
                bank_we[b]    = 1'b1;
                bank_re[b]    = 1'b0;
                bank_addr[b]  = r_clr_row;
                bank_wdata[b] = blem_pkg::FILL_BYTE;
            end else begin
                bank_we[b]    = en & n_s1.is_write;
                bank_re[b]    = en & ~n_s1.is_write;
                bank_addr[b]  = lane_addr[idx][blem_pkg::ROW_W+1:2];
                bank_wdata[b] = in_wdata[8*idx +: 8];
            end
        end
    end

    for (genvar g = 0; g < blem_pkg::LANES; g++) begin : g_bank
        blem_bank u_bank (
            .i_clk   (i_clk),
            .i_we    (bank_we[g]),
            .i_re    (bank_re[g]),
            .i_addr  (bank_addr[g]),
            .i_wdata (bank_wdata[g]),
            .o_rdata (bank_rdata[g])
        );
    end

    always_comb begin
        logic [1:0]  b;
        logic [31:0] value;
        value = '0;
        for (int i = 0; i < blem_pkg::LANES; i++) begin
            b = r_s1.off + 2'(i);
            value[8*i +: 8] = r_s1.byte_ok[i] ? bank_rdata[b] : 8'h00;
        end
        if (r_s1.is_write) begin
            value = '0;
        end else if (r_s1.sx) begin
            if (r_s1.asz == blem_pkg::ASZ_BYTE && value[7]) begin
                value = value | 32'hffffff00;
            end else if (r_s1.asz == blem_pkg::ASZ_HALF && value[15]) begin
                value = value | 32'hffff0000;
            end
        end
        n_out_data = value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= blem_pkg::ST_CLEAR;
            r_clr_row   <= '0;
            r_limit     <= blem_pkg::RESET_LIMIT;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_row   <= n_clr_row;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= blem_pkg::usable_size(i_cfg_data);
            end
            r_s1_valid  <= s_accept | (r_s1_valid & ~s1_move);
            r_out_valid <= s1_move | (r_out_valid & ~i_m_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1     <= n_s1;
            r_s1_oor <= n_s1_oor;
        end
        if (s1_move) begin
            r_out_data <= n_out_data;
            r_out_oor  <= r_s1_oor;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_oor;

endmodule

`default_nettype wire

FILE: sv/blem_checker.sv
`default_nettype none

module blem_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] o_m_tdata,
    input wire logic        o_m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("request accepted before clearing pass");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && o_m_tvalid && !i_m_tready) ##1 !i_m_tready
        |-> !o_s_tready)
        else $error("request accepted with both stages full");

endmodule

bind byte_addressed_little_endian_memory blem_checker u_blem_checker (.*);

`default_nettype wire

FILE: bench/byte_addressed_little_endian_memory_tb.sv
`default_nettype none

module byte_addressed_little_endian_memory_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import blem_pkg::*;

    localparam t_asize ASZ_WIDE    = 2'd3;
    localparam int     CYCLE_LIMIT = 200000;
    localparam int     DRAIN_CYCLES = 8;
    localparam int     HOLD_CYCLES = 300;

    typedef struct packed {
        logic        cmd;
        t_asize      asz;
        logic        sx;
        logic [31:0] addr;
        logic [31:0] wdata;
    } t_mem_access;

    typedef struct packed {
        logic [31:0] rdata;
        logic        oor;
    } t_mem_reply;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_data  = '0;
    logic              i_s_tvalid  = 1'b0;
    logic              o_s_tready;
    logic [63:0]       i_s_tdata   = '0;  // address, write_data
    logic [3:0]        i_s_tuser   = '0;  // cmd, access_size, sign_extend
    logic              o_m_tvalid;
    logic              i_m_tready  = 1'b0;
    logic [31:0]       o_m_tdata;          // read_data
    logic              o_m_tuser;          // out_of_range

    byte_addressed_little_endian_memory i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    logic [7:0]       shadow_bytes [MEM_BYTES];
    logic [CFG_W-1:0] size_setting = 17'h10000;
    t_mem_access      pending_accesses [$];
    t_mem_reply       expected_replies [$];
    int unsigned      send_idle_pct  = 0;
    int unsigned      recv_stall_pct = 0;
    int unsigned      cluster_base   = 0;
    int               mismatch_count = 0;
    int               cycle_count    = 0;
    logic             hold_request   = 1'b0;
    logic             hold_off       = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned usable_bytes(input logic [CFG_W-1:0] sz);
        int unsigned rounded;
        rounded = ((int'(sz) + 15) / 16) * 16;
        if (rounded > MEM_BYTES) begin
            rounded = MEM_BYTES;
        end
        return rounded;
    endfunction

    function automatic t_mem_reply predict_access(input t_mem_access acc);
        t_mem_reply  reply;
        int unsigned lim;
        int unsigned nbytes;
        logic [31:0] a;
        lim    = usable_bytes(size_setting);
        nbytes = (acc.asz == ASZ_BYTE) ? 1 : (acc.asz == ASZ_HALF) ? 2 : 4;
        reply  = '0;
        for (int i = 0; i < nbytes; i++) begin
            a = acc.addr + 32'(i);
            if (a >= lim) begin
                reply.oor = 1'b1;
            end else if (acc.cmd == CMD_WRITE) begin
                shadow_bytes[a[15:0]] = acc.wdata[8*i +: 8];
            end else begin
                reply.rdata[8*i +: 8] = shadow_bytes[a[15:0]];
            end
        end
        if (acc.cmd == CMD_WRITE) begin
            reply.rdata = '0;
        end else if (acc.sx) begin
            if (nbytes == 1 && reply.rdata[7]) begin
                reply.rdata[31:8] = '1;
            end else if (nbytes == 2 && reply.rdata[15]) begin
                reply.rdata[31:16] = '1;
            end
        end
        return reply;
    endfunction

    function automatic t_mem_access make_access(input logic cmd, input t_asize asz,
                                                input logic sx, input logic [31:0] addr,
                                                input logic [31:0] wdata);
        t_mem_access acc;
        acc.cmd   = cmd;
        acc.asz   = asz;
        acc.sx    = sx;
        acc.addr  = addr;
        acc.wdata = wdata;
        return acc;
    endfunction

    function automatic t_mem_access random_access();
        t_mem_access acc;
        int unsigned lim;
        int unsigned pick;
        lim       = usable_bytes(size_setting);
        pick      = $urandom_range(99, 0);
        acc.cmd   = 1'($urandom_range(1, 0));
        acc.asz   = t_asize'($urandom_range(3, 0));
        acc.sx    = 1'($urandom_range(1, 0));
        acc.wdata = $urandom;
        if (pick < 40) begin
            acc.addr = 32'(cluster_base + $urandom_range(63, 0));
        end else if (pick < 60) begin
            acc.addr = 32'(lim) - 32'd8 + 32'($urandom_range(15, 0));
        end else if (pick < 70) begin
            acc.addr = 32'hffff_fff8 + 32'($urandom_range(15, 0));
        end else if (pick < 85 && lim != 0) begin
            acc.addr = 32'($urandom_range(lim - 1, 0));
        end else begin
            acc.addr = $urandom;
        end
        return acc;
    endfunction

    task automatic report_mismatch(input string what);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic write_size(input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        size_setting = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending_accesses.size() != 0 || expected_replies.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int count, input int unsigned sidle,
                              input int unsigned rstall);
        int unsigned lim;
        lim            = usable_bytes(size_setting);
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        cluster_base   = (lim >= 64) ? $urandom_range(lim - 64, 0) : 0;
        for (int n = 0; n < count; n++) begin
            pending_accesses.push_back(random_access());
        end
        drain();
    endtask

    // request side
    always @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready === 1'b1) begin
            expected_replies.push_back(predict_access(pending_accesses.pop_front()));
        end
        if (!i_s_tvalid || o_s_tready === 1'b1) begin
            if (pending_accesses.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {pending_accesses[0].wdata, pending_accesses[0].addr};
                i_s_tuser  <= {pending_accesses[0].sx, pending_accesses[0].asz,
                               pending_accesses[0].cmd};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // reply side
    always @(posedge i_clk) begin
        t_mem_reply want;
        if (o_m_tvalid === 1'b1 && i_m_tready) begin
            if (expected_replies.size() == 0) begin
                report_mismatch($sformatf("reply with none pending: data %08h oor %0b",
                                          o_m_tdata, o_m_tuser));
            end else begin
                want = expected_replies.pop_front();
                if (o_m_tdata !== want.rdata) begin
                    report_mismatch($sformatf("read_data %08h, want %08h",
                                              o_m_tdata, want.rdata));
                end
                if (o_m_tuser !== want.oor) begin
                    report_mismatch($sformatf("out_of_range %0b, want %0b",
                                              o_m_tuser, want.oor));
                end
            end
        end
        i_m_tready <= !hold_off && ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // hold off replies long enough to back up the request side
    initial begin
        wait (hold_request);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        for (int a = 0; a < MEM_BYTES; a++) begin
            shadow_bytes[a] = FILL_BYTE;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_size(17'h10000);

        pending_accesses.push_back(make_access(CMD_READ,  ASZ_WORD, 1'b0, 32'h0, 32'h0));
        pending_accesses.push_back(make_access(CMD_READ,  ASZ_BYTE, 1'b1, 32'h0, 32'h0));
        pending_accesses.push_back(make_access(CMD_READ,  ASZ_HALF, 1'b1, 32'h1, 32'h0));
        pending_accesses.push_back(make_access(CMD_READ,  ASZ_WORD, 1'b1, 32'h0, 32'h0));
        pending_accesses.push_back(make_access(CMD_WRITE, ASZ_WORD, 1'b1, 32'h100,
                                               32'h1234_5678));
        pending_accesses.push_back(make_access(CMD_READ,  ASZ_BYTE, 1'b1, 32'h100, 32'h0));
        pending_accesses.push_back(make_access(CMD_READ,  ASZ_BYTE, 1'b1, 32'h103, 32'h0));
        pending_accesses.push_back(make_access(CMD_READ,  ASZ_HALF, 1'b0, 32'h101, 32'h0));
        pending_accesses.push_back(make_access(CMD_WRITE, ASZ_BYTE, 1'b1, 32'h200,
                                               32'hffff_ff7f));
        pending_accesses.push_back(make_access(CMD_READ,  ASZ_BYTE, 1'b1, 32'h200, 32'h0));
        pending_accesses.push_back(make_access(CMD_WRITE, ASZ_HALF, 1'b0, 32'h202,
                                               32'h0000_8001));
        pending_accesses.push_back(make_access(CMD_READ,  ASZ_HALF, 1'b1, 32'h202, 32'h0));
        pending_accesses.push_back(make_access(CMD_READ,  ASZ_WORD, 1'b0, 32'h200, 32'h0));
        pending_accesses.push_back(make_access(CMD_WRITE, ASZ_WIDE, 1'b0, 32'h300,
                                               32'hdead_beef));
        pending_accesses.push_back(make_access(CMD_READ,  ASZ_WIDE, 1'b1, 32'h300, 32'h0));
        pending_accesses.push_back(make_access(CMD_WRITE, ASZ_WORD, 1'b0, 32'hffff_fffd,
                                               32'haabb_ccdd));
        pending_accesses.push_back(make_access(CMD_READ,  ASZ_WORD, 1'b0, 32'hffff_ffff,
                                               32'h0));
        pending_accesses.push_back(make_access(CMD_READ,  ASZ_WORD, 1'b1, 32'hfffe, 32'h0));
        pending_accesses.push_back(make_access(CMD_WRITE, ASZ_WORD, 1'b0, 32'hfffc,
                                               32'hffff_ffff));
        pending_accesses.push_back(make_access(CMD_READ,  ASZ_WORD, 1'b0, 32'hfffc, 32'h0));
        pending_accesses.push_back(make_access(CMD_WRITE, ASZ_BYTE, 1'b0, 32'hffff_ffff,
                                               32'h0));
        pending_accesses.push_back(make_access(CMD_READ,  ASZ_BYTE, 1'b1, 32'hffff_ffff,
                                               32'h0));
        pending_accesses.push_back(make_access(CMD_READ,  ASZ_HALF, 1'b0, 32'h1_0000, 32'h0));
        drain();

        hold_request = 1'b1;
        run_random(150, 0, 0);
        write_size(17'd17);
        run_random(120, 74, 0);
        write_size(17'd0);
        run_random(60, 0, 74);
        write_size(17'd65535);
        run_random(150, 31, 31);
        write_size(17'($urandom_range(65536, 1)));
        run_random(120, 0, 74);
        write_size(17'd16);
        run_random(80, 31, 31);
        write_size(17'd65520);
        run_random(100, 0, 0);
        write_size(17'h10000);
        run_random(100, 74, 74);

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
sv/blem_pkg.sv
sv/blem_bank.sv
sv/byte_addressed_little_endian_memory.sv
sv/blem_checker.sv
bench/byte_addressed_little_endian_memory_tb.sv
